// File: design/aar_pkg.sv
// Shared types and constants for the box refit unit.
package aar_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned RowW   = 48;
  localparam int unsigned EntW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegRowX   = 3'd0,
    RegRowY   = 3'd1,
    RegRowZ   = 3'd2,
    RegShiftX = 3'd3,
    RegShiftY = 3'd4,
    RegShiftZ = 3'd5
  } cfg_reg_e;

endpackage

// File: design/aabb_affine_refit_unit.sv
// Top level of the box refit unit: center scale, corner transform, min/max.
// Each row norm is computed from the configured matrix by a bit-serial
// square root. That pass runs after reset and after any matrix write, and
// no box is accepted while it runs. After that, one box a cycle is accepted
// while the pipeline is not held by a stalled output. The pipeline has nine
// register stages: capture and center sum, center multiply, round to scaled
// center, corner differences and base term, matrix products, min/max sums,
// round, clamp, and the output register. The output may stall; the pipeline
// then holds without loss.
module aabb_affine_refit_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [aar_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [aar_pkg::RowW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [31:0]          low_x_i,
  input  logic signed [31:0]          low_y_i,
  input  logic signed [31:0]          low_z_i,
  input  logic signed [31:0]          high_x_i,
  input  logic signed [31:0]          high_y_i,
  input  logic signed [31:0]          high_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          new_low_x_o,
  output logic signed [31:0]          new_low_y_o,
  output logic signed [31:0]          new_low_z_o,
  output logic signed [31:0]          new_high_x_o,
  output logic signed [31:0]          new_high_y_o,
  output logic signed [31:0]          new_high_z_o,
  output logic                        overflow_o
);
  import aar_pkg::*;

  localparam int unsigned NSt = 9;

  logic [RowW-1:0] row_q [3];
  logic signed [31:0] sh_q [3];

  // sqrt engine
  logic [4:0]  sq_cnt_q;
  logic        sq_busy_q;
  logic [37:0] sq_v_q [3];
  logic [37:0] sq_rem_q [3];
  logic [19:0] sq_r_q [3];
  logic [19:0] mag_q [3];

  function automatic logic [37:0] row_sq(input logic [RowW-1:0] r);
    logic signed [15:0] e0, e1, e2;
    logic [37:0] s;
    e0 = r[15:0]; e1 = r[31:16]; e2 = r[47:32];
    s = 38'(32'(e0) * 32'(e0)) + 38'(32'(e1) * 32'(e1)) + 38'(32'(e2) * 32'(e2));
    return {s[33:0], 4'b0};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= 48'h4000;
      row_q[1] <= 48'h4000_0000;
      row_q[2] <= 48'h4000_0000_0000;
      sh_q[0] <= '0; sh_q[1] <= '0; sh_q[2] <= '0;
      sq_busy_q <= 1'b1;
      sq_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegRowX:   row_q[0] <= cfg_data_i;
          RegRowY:   row_q[1] <= cfg_data_i;
          RegRowZ:   row_q[2] <= cfg_data_i;
          RegShiftX: sh_q[0] <= cfg_data_i[31:0];
          RegShiftY: sh_q[1] <= cfg_data_i[31:0];
          RegShiftZ: sh_q[2] <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (cfg_we_i && (cfg_idx_i == RegRowX || cfg_idx_i == RegRowY ||
                       cfg_idx_i == RegRowZ)) begin
        sq_busy_q <= 1'b1;
        sq_cnt_q  <= '0;
      end else if (sq_busy_q) begin
        sq_cnt_q <= sq_cnt_q + 5'd1;
        if (sq_cnt_q == 5'd20) sq_busy_q <= 1'b0;
      end
    end
  end

  // restoring sqrt, two bits per step; step 0 loads
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (sq_cnt_q == 5'd0) begin
        sq_v_q[a]   <= row_sq(row_q[a]);
        sq_rem_q[a] <= '0;
        sq_r_q[a]   <= '0;
      end else if (sq_cnt_q <= 5'd19) begin
        logic [39:0] rem2, trial;
        rem2  = {sq_rem_q[a], sq_v_q[a][37:36]};
        trial = {18'd0, sq_r_q[a], 2'b01};
        sq_v_q[a] <= {sq_v_q[a][35:0], 2'b00};
        if (rem2 >= trial) begin
          sq_rem_q[a] <= 38'(rem2 - trial);
          sq_r_q[a]   <= {sq_r_q[a][18:0], 1'b1};
        end else begin
          sq_rem_q[a] <= rem2[37:0];
          sq_r_q[a]   <= {sq_r_q[a][18:0], 1'b0};
        end
      end else if (sq_cnt_q == 5'd20) begin
        mag_q[a] <= sq_r_q[a];
      end
    end
  end

  // pipeline control
  logic [NSt-1:0] vld_q;
  logic [NSt-1:0] adv;
  always_comb begin
    adv[NSt-1] = !vld_q[NSt-1] || out_ready_i;
    for (int i = NSt-2; i >= 0; i--) adv[i] = !vld_q[i] || adv[i+1];
  end
  assign in_ready_o = adv[0] && !sq_busy_q;
  logic acc_in;
  assign acc_in = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else begin
      if (adv[0]) vld_q[0] <= acc_in;
      for (int i = 1; i < NSt; i++) if (adv[i]) vld_q[i] <= vld_q[i-1];
    end
  end

  // S0: capture, sum
  logic signed [31:0] lo0_q [3], hi0_q [3];
  logic signed [32:0] s0_q [3];
  logic signed [31:0] li [3], hi_i [3];
  assign li[0] = low_x_i;  assign li[1] = low_y_i;  assign li[2] = low_z_i;
  assign hi_i[0] = high_x_i; assign hi_i[1] = high_y_i; assign hi_i[2] = high_z_i;
  always_ff @(posedge clk_i) if (adv[0]) for (int a = 0; a < 3; a++) begin
    lo0_q[a] <= li[a]; hi0_q[a] <= hi_i[a];
    s0_q[a]  <= 33'(li[a]) + 33'(hi_i[a]);
  end

  // S1: s * mag
  logic signed [31:0] lo1_q [3], hi1_q [3];
  logic signed [53:0] p1_q [3];
  always_ff @(posedge clk_i) if (adv[1]) for (int a = 0; a < 3; a++) begin
    lo1_q[a] <= lo0_q[a]; hi1_q[a] <= hi0_q[a];
    p1_q[a]  <= 54'(s0_q[a]) * $signed({34'd0, mag_q[a]});
  end

  // S2: round to c'
  logic signed [31:0] lo2_q [3], hi2_q [3];
  logic signed [37:0] c2_q [3];
  always_ff @(posedge clk_i) if (adv[2]) for (int a = 0; a < 3; a++) begin
    logic signed [53:0] t;
    t = p1_q[a] + 54'sd65536;
    lo2_q[a] <= lo1_q[a]; hi2_q[a] <= hi1_q[a];
    c2_q[a]  <= 38'(t >>> 17);
  end

  // S3: differences and base term
  logic signed [38:0] dl3_q [3], dh3_q [3];
  logic signed [52:0] b3_q [3];
  always_ff @(posedge clk_i) if (adv[3]) for (int a = 0; a < 3; a++) begin
    dl3_q[a] <= 39'(lo2_q[a]) - 39'(c2_q[a]);
    dh3_q[a] <= 39'(hi2_q[a]) - 39'(c2_q[a]);
    b3_q[a]  <= (53'(sh_q[a]) + 53'(c2_q[a])) <<< 14;
  end

  // S4: products M[r][j]*d for both choices
  logic signed [54:0] pl4_q [3][3], ph4_q [3][3];
  logic signed [52:0] b4_q [3];
  always_ff @(posedge clk_i) if (adv[4]) for (int r = 0; r < 3; r++) begin
    b4_q[r] <= b3_q[r];
    for (int j = 0; j < 3; j++) begin
      logic signed [15:0] e;
      e = row_q[r][16*j +: 16];
      pl4_q[r][j] <= 55'(e) * 55'(dl3_q[j]);
      ph4_q[r][j] <= 55'(e) * 55'(dh3_q[j]);
    end
  end

  // S5: per row, min and max of the sum chosen termwise
  logic signed [57:0] mn5_q [3], mx5_q [3];
  always_ff @(posedge clk_i) if (adv[5]) for (int r = 0; r < 3; r++) begin
    logic signed [57:0] smn, smx;
    smn = 58'(b4_q[r]); smx = 58'(b4_q[r]);
    for (int j = 0; j < 3; j++) begin
      if (pl4_q[r][j] < ph4_q[r][j]) begin
        smn = smn + 58'(pl4_q[r][j]); smx = smx + 58'(ph4_q[r][j]);
      end else begin
        smn = smn + 58'(ph4_q[r][j]); smx = smx + 58'(pl4_q[r][j]);
      end
    end
    mn5_q[r] <= smn; mx5_q[r] <= smx;
  end

  // S6: round
  logic signed [44:0] mn6_q [3], mx6_q [3];
  always_ff @(posedge clk_i) if (adv[6]) for (int r = 0; r < 3; r++) begin
    logic signed [57:0] a0, a1;
    a0 = mn5_q[r] + 58'sd8192; a1 = mx5_q[r] + 58'sd8192;
    mn6_q[r] <= 45'(a0 >>> 14); mx6_q[r] <= 45'(a1 >>> 14);
  end

  // S7: clamp
  logic signed [31:0] mn7_q [3], mx7_q [3];
  logic [5:0] of7_q;
  function automatic logic [32:0] clamp(input logic signed [44:0] v);
    if (v > 45'sd2147483647) return {1'b1, 32'h7fff_ffff};
    if (v < -45'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction
  always_ff @(posedge clk_i) if (adv[7]) for (int r = 0; r < 3; r++) begin
    {of7_q[r], mn7_q[r]}   <= clamp(mn6_q[r]);
    {of7_q[r+3], mx7_q[r]} <= clamp(mx6_q[r]);
  end

  // S8: output register
  logic signed [31:0] mn8_q [3], mx8_q [3];
  logic of8_q;
  always_ff @(posedge clk_i) if (adv[8]) begin
    for (int r = 0; r < 3; r++) begin mn8_q[r] <= mn7_q[r]; mx8_q[r] <= mx7_q[r]; end
    of8_q <= |of7_q;
  end

  assign out_valid_o  = vld_q[NSt-1];
  assign new_low_x_o  = mn8_q[0];
  assign new_low_y_o  = mn8_q[1];
  assign new_low_z_o  = mn8_q[2];
  assign new_high_x_o = mx8_q[0];
  assign new_high_y_o = mx8_q[1];
  assign new_high_z_o = mx8_q[2];
  assign overflow_o   = of8_q;

endmodule
